### hw/rtl/xrr_pkg.sv
// ----------------------------------------------------------------------------
// xrr_pkg
// Shared types, command codes and generator step functions for the
// xorshift random generator with range reduction.
// ----------------------------------------------------------------------------
package xrr_pkg;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_SEED  = 2'd0;
	localparam cmd_t CMD_DRAW  = 2'd1;
	localparam cmd_t CMD_RANGE = 2'd2;

	typedef logic [1:0] wsel_t;
	localparam wsel_t WSEL_8  = 2'd0;
	localparam wsel_t WSEL_16 = 2'd1;
	localparam wsel_t WSEL_32 = 2'd2;

	localparam int DIV_STEPS = 32;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic load;
		logic div_step;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic out_free;
	} dp_stat_t;

	function automatic logic [7:0] step8(input logic [7:0] s_in);
		logic [7:0] s;
		s = s_in;
		s = s ^ (s << 7);
		s = s ^ (s >> 5);
		s = s ^ (s << 3);
		return s;
	endfunction

	function automatic logic [15:0] step16(input logic [15:0] s_in);
		logic [15:0] s;
		s = s_in;
		s = s ^ (s << 13);
		s = s ^ (s >> 9);
		s = s ^ (s << 7);
		return s;
	endfunction

	function automatic logic [31:0] step32(input logic [31:0] s_in);
		logic [31:0] s;
		s = s_in;
		s = s ^ (s << 13);
		s = s ^ (s >> 17);
		s = s ^ (s << 5);
		return s;
	endfunction

endpackage

### hw/rtl/xorshift_random_with_range.sv
// ----------------------------------------------------------------------------
// xorshift_random_with_range
// Seed, raw draw and empty-span range: the result goes to the output register
// without division. Range draw: first runs the one-bit-per-cycle remainder
// unit (32 steps). The next input is taken while the previous result waits
// in the output register.
// Reset: generators load 1, no result pending.
// ----------------------------------------------------------------------------
module xorshift_random_with_range (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  xrr_pkg::cmd_t  command,
	input  xrr_pkg::wsel_t width_select,
	input  logic [31:0]    seed,
	input  logic [31:0]    low_bound,
	input  logic [31:0]    high_bound,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [31:0]    value,
	output logic           range_error
);
	import xrr_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	xrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	xrr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.stat         (dp_stat),
		.command      (command),
		.width_select (width_select),
		.seed         (seed),
		.low_bound    (low_bound),
		.high_bound   (high_bound),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.value        (value),
		.range_error  (range_error)
	);

endmodule

### hw/rtl/xrr_ctrl.sv
// ----------------------------------------------------------------------------
// xrr_ctrl
// Sequencer: takes a transaction, runs the remainder unit when a range
// draw needs it, then hands the result to the output register.
// ----------------------------------------------------------------------------
module xrr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  xrr_pkg::dp_stat_t stat,
	output xrr_pkg::dp_cmd_t  cmd
);
	import xrr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;

	assign in_stall     = (state_q != S_IDLE);
	assign cmd.load     = (state_q == S_IDLE) && in_valid;
	assign cmd.div_step = (state_q == S_DIV);
	assign cmd.emit     = (state_q == S_EMIT) && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q   <= CNT_W'(DIV_STEPS - 1);
						state_q <= stat.need_div ? S_DIV : S_EMIT;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/xrr_dp.sv
// ----------------------------------------------------------------------------
// xrr_dp
// Datapath: the three generators, operand registers, a bit-serial
// restoring remainder unit and the output register.
// ----------------------------------------------------------------------------
module xrr_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  xrr_pkg::dp_cmd_t  cmd,
	output xrr_pkg::dp_stat_t stat,
	input  xrr_pkg::cmd_t     command,
	input  xrr_pkg::wsel_t    width_select,
	input  logic [31:0]       seed,
	input  logic [31:0]       low_bound,
	input  logic [31:0]       high_bound,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [31:0]       value,
	output logic              range_error
);
	import xrr_pkg::*;

	logic [7:0]  gen_small_q;
	logic [15:0] gen_medium_q;
	logic [31:0] gen_large_q;

	logic [7:0]  nxt_small;
	logic [15:0] nxt_medium;
	logic [31:0] nxt_large;
	logic [31:0] draw_v;
	logic [31:0] lo_m;
	logic [31:0] hi_m;
	logic        wsel_ok;
	logic        is_range;
	logic [31:0] res_now;
	logic        err_now;

	logic [31:0] res_q;
	logic        err_q;
	logic        use_sum_q;
	logic [31:0] lo_q;
	logic [31:0] span_q;
	logic [31:0] dvd_q;
	logic [31:0] rem_q;
	logic [32:0] trial;

	logic        out_valid_q;
	logic [31:0] value_q;
	logic        range_error_q;

	assign stat.out_free = !out_valid_q || !out_stall;
	assign is_range      = (command == CMD_RANGE);
	assign stat.need_div = is_range && wsel_ok && (hi_m > lo_m);

	always_comb begin
		nxt_small  = gen_small_q;
		nxt_medium = gen_medium_q;
		nxt_large  = gen_large_q;
		draw_v     = '0;
		lo_m       = '0;
		hi_m       = '0;
		wsel_ok    = 1'b1;
		unique case (width_select)
			WSEL_8: begin
				draw_v = {24'd0, step8(gen_small_q)};
				lo_m   = {24'd0, low_bound[7:0]};
				hi_m   = {24'd0, high_bound[7:0]};
			end
			WSEL_16: begin
				draw_v = {16'd0, step16(gen_medium_q)};
				lo_m   = {16'd0, low_bound[15:0]};
				hi_m   = {16'd0, high_bound[15:0]};
			end
			WSEL_32: begin
				draw_v = step32(gen_large_q);
				lo_m   = low_bound;
				hi_m   = high_bound;
			end
			default: begin
				wsel_ok = 1'b0;
			end
		endcase

		res_now = '0;
		err_now = 1'b0;
		unique case (command) inside
			CMD_SEED: begin
				nxt_small  = (seed[7:0] == '0) ? 8'd1 : seed[7:0];
				nxt_medium = (seed[15:0] == '0) ? 16'd1 : seed[15:0];
				nxt_large  = (seed == '0) ? 32'd1 : seed;
			end
			CMD_DRAW, CMD_RANGE: begin
				if (wsel_ok) begin
					unique case (width_select)
						WSEL_8:  nxt_small  = draw_v[7:0];
						WSEL_16: nxt_medium = draw_v[15:0];
						default: nxt_large  = draw_v;
					endcase
					if (!is_range) begin
						res_now = draw_v;
					end else if (hi_m <= lo_m) begin
						res_now = lo_m;
						err_now = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign trial = {rem_q, dvd_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_small_q  <= 8'd1;
			gen_medium_q <= 16'd1;
			gen_large_q  <= 32'd1;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				gen_small_q  <= nxt_small;
				gen_medium_q <= nxt_medium;
				gen_large_q  <= nxt_large;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q     <= res_now;
			err_q     <= err_now;
			use_sum_q <= stat.need_div;
			lo_q      <= lo_m;
			span_q    <= hi_m - lo_m;
			dvd_q     <= draw_v;
			rem_q     <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, span_q}) begin
				rem_q <= 32'(trial - {1'b0, span_q});
			end else begin
				rem_q <= trial[31:0];
			end
		end
		if (cmd.emit) begin
			value_q       <= use_sum_q ? (lo_q + rem_q) : res_q;
			range_error_q <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign range_error = range_error_q;

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for xorshift_random_with_range. The bench keeps its own
// copy of the 8, 16 and 32 bit generators and checks every result in order.
// It runs directed seed, draw, range and odd-code transactions, then random
// traffic with several sender idle and receiver stall rates.
// ----------------------------------------------------------------------------
module tb;
	import xrr_pkg::*;

	localparam cmd_t  CMD_NOP    = 2'd3;
	localparam wsel_t WSEL_NONE  = 2'd3;
	localparam int    WDOG_LIMIT = 4000;
	localparam int    TAIL_WAIT  = 40;
	localparam int    MAX_REPORT = 10;

	typedef struct {
		logic [31:0] value;
		logic        range_error;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	cmd_t        command;
	wsel_t       width_select;
	logic [31:0] seed;
	logic [31:0] low_bound;
	logic [31:0] high_bound;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] value;
	logic        range_error;

	logic [7:0]  rng8;
	logic [15:0] rng16;
	logic [31:0] rng32;
	result_t     pending_results[$];

	int idle_pct;
	int stall_pct;
	int mismatches = 0;
	int n_sent;
	int n_checked = 0;
	int n_errflag;
	int idle_cycles = 0;

	xorshift_random_with_range dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.width_select (width_select),
		.seed         (seed),
		.low_bound    (low_bound),
		.high_bound   (high_bound),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.range_error  (range_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// advances the bench copy of the generators and forms the expected result
	function automatic result_t predict_result(input cmd_t c, input wsel_t w,
			input logic [31:0] sd, input logic [31:0] lo, input logic [31:0] hi);
		result_t     r;
		logic [31:0] raw;
		logic [31:0] mask;
		r.value = '0;
		r.range_error = 1'b0;
		raw = '0;
		mask = '0;
		if (c == CMD_SEED) begin
			rng8  = (sd[7:0] == 8'd0) ? 8'd1 : sd[7:0];
			rng16 = (sd[15:0] == 16'd0) ? 16'd1 : sd[15:0];
			rng32 = (sd == 32'd0) ? 32'd1 : sd;
		end else if ((c == CMD_DRAW || c == CMD_RANGE) && w != WSEL_NONE) begin
			case (w)
				WSEL_8: begin
					rng8 = rng8 ^ {rng8[0], 7'd0};
					rng8 = rng8 ^ {5'd0, rng8[7:5]};
					rng8 = rng8 ^ {rng8[4:0], 3'd0};
					raw = {24'd0, rng8};
					mask = 32'h0000_00FF;
				end
				WSEL_16: begin
					rng16 = rng16 ^ {rng16[2:0], 13'd0};
					rng16 = rng16 ^ {9'd0, rng16[15:9]};
					rng16 = rng16 ^ {rng16[8:0], 7'd0};
					raw = {16'd0, rng16};
					mask = 32'h0000_FFFF;
				end
				default: begin
					rng32 = rng32 ^ {rng32[18:0], 13'd0};
					rng32 = rng32 ^ {17'd0, rng32[31:17]};
					rng32 = rng32 ^ {rng32[26:0], 5'd0};
					raw = rng32;
					mask = 32'hFFFF_FFFF;
				end
			endcase
			if (c == CMD_DRAW) begin
				r.value = raw;
			end else if ((hi & mask) <= (lo & mask)) begin
				r.value = lo & mask;
				r.range_error = 1'b1;
			end else begin
				r.value = ((lo & mask) + raw % ((hi & mask) - (lo & mask))) & mask;
			end
		end
		return r;
	endfunction

	task automatic send_txn(input cmd_t c, input wsel_t w, input logic [31:0] sd,
			input logic [31:0] lo, input logic [31:0] hi);
		result_t r;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		width_select <= w;
		seed <= sd;
		low_bound <= lo;
		high_bound <= hi;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = predict_result(c, w, sd, lo, hi);
		pending_results.push_back(r);
		n_sent++;
		if (r.range_error)
			n_errflag++;
	endtask

	// sender holds off until every outstanding result is back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_seed_and_draw();
		wsel_t w;
		send_txn(CMD_SEED, WSEL_8, 32'h0000_0000, '0, '0);
		for (int i = 0; i < 3; i++) begin
			w = wsel_t'(i);
			send_txn(CMD_DRAW, w, $urandom, $urandom, $urandom);
		end
		send_txn(CMD_SEED, WSEL_32, 32'hFFFF_FFFF, '0, '0);
		for (int i = 0; i < 3; i++) begin
			w = wsel_t'(i);
			send_txn(CMD_DRAW, w, '0, '0, '0);
		end
		send_txn(CMD_SEED, WSEL_16, 32'h0001_0000, '0, '0);
		for (int i = 0; i < 3; i++) begin
			w = wsel_t'(i);
			send_txn(CMD_DRAW, w, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		end
	endtask

	task automatic test_range_cases();
		send_txn(CMD_RANGE, WSEL_32, '0, 32'h0000_0000, 32'hFFFF_FFFF);
		send_txn(CMD_RANGE, WSEL_32, '0, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_txn(CMD_RANGE, WSEL_32, '0, 32'h1234_5678, 32'h1234_5678);
		send_txn(CMD_RANGE, WSEL_16, '0, 32'h0000_8000, 32'h0000_0100);
		send_txn(CMD_RANGE, WSEL_8, '0, 32'hFFFF_FF10, 32'h0000_0020);
		send_txn(CMD_RANGE, WSEL_16, '0, 32'h0000_0000, 32'h0000_0001);
		send_txn(CMD_RANGE, WSEL_8, '0, 32'h0000_0000, 32'h0000_01FF);
	endtask

	task automatic test_odd_codes();
		send_txn(CMD_DRAW, WSEL_NONE, '0, '0, '0);
		send_txn(CMD_RANGE, WSEL_NONE, '0, 32'd1, 32'd100);
		send_txn(CMD_NOP, WSEL_8, 32'hA5A5_A5A5, 32'd3, 32'd9);
		send_txn(CMD_SEED, WSEL_NONE, 32'hC3C3_0000, '0, '0);
		send_txn(CMD_DRAW, WSEL_8, '0, '0, '0);
	endtask

	task automatic test_random_traffic(input int count, input int idle, input int stall);
		cmd_t        c;
		wsel_t       w;
		logic [31:0] lo;
		logic [31:0] hi;
		int          pick;
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 5)
				c = CMD_SEED;
			else if (pick < 7)
				c = CMD_NOP;
			else if (pick < 50)
				c = CMD_DRAW;
			else
				c = CMD_RANGE;
			w = ($urandom_range(29) == 0) ? WSEL_NONE : wsel_t'($urandom_range(2));
			case ($urandom_range(3))
				0: lo = $urandom;
				1: lo = $urandom_range(255);
				2: lo = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
				default: lo = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			endcase
			case ($urandom_range(3))
				0: hi = $urandom;
				1: hi = lo + $urandom_range(300);
				2: hi = lo + $urandom;
				default: hi = $urandom_range(1) ? 32'hFFFF_FFFF : lo;
			endcase
			send_txn(c, w, $urandom, lo, hi);
		end
		drain_results();
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORT)
					$display("%0t: unexpected result value=%h range_error=%b",
						$time, value, range_error);
			end else begin
				exp_r = pending_results.pop_front();
				n_checked++;
				if (value !== exp_r.value || range_error !== exp_r.range_error) begin
					mismatches++;
					if (mismatches <= MAX_REPORT)
						$display("%0t: mismatch value exp=%h act=%h range_error exp=%b act=%b",
							$time, exp_r.value, value, exp_r.range_error, range_error);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				pending_results.size());
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_SEED;
		width_select = WSEL_8;
		seed = '0;
		low_bound = '0;
		high_bound = '0;
		rng8 = 8'd1;
		rng16 = 16'd1;
		rng32 = 32'd1;
		idle_pct = 0;
		stall_pct = 0;
		n_sent = 0;
		n_errflag = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_seed_and_draw();
		test_range_cases();
		test_odd_codes();
		drain_results();
		test_random_traffic(250, 0, 0);
		test_random_traffic(250, 81, 0);
		test_random_traffic(250, 0, 81);
		test_random_traffic(250, 17, 17);

		repeat (TAIL_WAIT) @(posedge clk);
		$display("tb: %0d transactions sent, %0d results checked, %0d empty-span flags",
			n_sent, n_checked, n_errflag);
		$display("tb: seeds, raw and ranged draws at all widths, odd codes, four idle mixes");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: %0d mismatches", mismatches);
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
